// ===== rtl/rpa_pkg.sv =====
`timescale 1ns / 1ps

package rpa_pkg;

    localparam logic signed [31:0] TRIG_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [31:0] pivot_z;
        logic signed [31:0] unit_u;
        logic signed [31:0] unit_v;
        logic signed [31:0] unit_w;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
        logic               bad;
    } t_axis_cfg;

    typedef enum logic [4:0] {
        DS_START,
        DS_NORM,
        DS_SUMSQ,
        DS_SQRT,
        DS_UDIV,
        DS_UDONE,
        DS_ANGLE,
        DS_QUAD,
        DS_RMUL,
        DS_RHIGH,
        DS_RDONE,
        DS_TMUL,
        DS_TDIV,
        DS_TDONE,
        DS_FIN,
        DS_DIV,
        DS_READY
    } t_dstate;

endpackage

// ===== rtl/rpa_pipe.sv =====
`timescale 1ns / 1ps

module rpa_pipe #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rpa_pkg::t_axis_cfg            i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    input  logic signed [COORD_WIDTH-1:0] i_pz,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_rx,
    output logic signed [COORD_WIDTH-1:0] o_ry,
    output logic signed [COORD_WIDTH-1:0] o_rz,
    output logic                          o_last,
    output logic                          o_bad
);
    import rpa_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = ((CW > 32) ? CW : 32) + 1;
    localparam int PW  = DW + 1;
    localparam int SW  = PW + 2;
    localparam int CRW = PW + 1;
    localparam int TW  = PW + 3;
    localparam int UW  = PW + 2;
    localparam int VW  = PW + 4;
    localparam int RW  = PW + 6;
    localparam int PRW = RW + 34;

    function automatic logic signed [RW-1:0] f_mulq(input logic signed [RW-1:0] a,
                                                    input logic signed [33:0] q);
        logic [RW-1:0]  ma;
        logic [33:0]    mq;
        logic [PRW-1:0] p;
        logic [PRW-1:0] r;
        ma = a[RW-1] ? RW'(-a) : RW'(a);
        mq = q[33] ? 34'(-q) : 34'(q);
        p  = PRW'(ma) * PRW'(mq);
        r  = (p + (PRW'(1) << 29)) >> 30;
        f_mulq = (a[RW-1] ^ q[33]) ? -RW'(r) : RW'(r);
    endfunction

    logic signed [31:0]   k    [3];
    logic signed [31:0]   piv  [3];
    logic signed [CW-1:0] pt   [3];
    logic signed [33:0]   cos_q;
    logic signed [33:0]   sin_q;
    logic signed [33:0]   omc_q;

    logic [6:1] r_v;
    logic [6:1] en;

    logic signed [DW-1:0]  r1_dd [3];
    logic signed [CW-1:0]  r1_pt [3];
    logic                  r1_last;
    logic signed [PW-1:0]  r2_dt [3];
    logic signed [PW-1:0]  r2_ca [3];
    logic signed [PW-1:0]  r2_cb [3];
    logic signed [PW-1:0]  r2_dc [3];
    logic signed [CW-1:0]  r2_pt [3];
    logic                  r2_last;
    logic signed [SW-1:0]  r3_dot;
    logic signed [CRW-1:0] r3_cr [3];
    logic signed [PW-1:0]  r3_dc [3];
    logic signed [CW-1:0]  r3_pt [3];
    logic                  r3_last;
    logic signed [TW-1:0]  r4_t  [3];
    logic signed [UW-1:0]  r4_u  [3];
    logic signed [PW-1:0]  r4_dc [3];
    logic signed [CW-1:0]  r4_pt [3];
    logic                  r4_last;
    logic signed [VW-1:0]  r5_v  [3];
    logic signed [UW-1:0]  r5_u  [3];
    logic signed [PW-1:0]  r5_dc [3];
    logic signed [CW-1:0]  r5_pt [3];
    logic                  r5_last;
    logic signed [CW-1:0]  r6_r  [3];
    logic                  r6_last;
    logic signed [CW-1:0]  n6_r  [3];

    assign k[0]   = i_cfg.unit_u;
    assign k[1]   = i_cfg.unit_v;
    assign k[2]   = i_cfg.unit_w;
    assign piv[0] = i_cfg.pivot_x;
    assign piv[1] = i_cfg.pivot_y;
    assign piv[2] = i_cfg.pivot_z;
    assign pt[0]  = i_px;
    assign pt[1]  = i_py;
    assign pt[2]  = i_pz;
    assign cos_q  = 34'(i_cfg.cos_v);
    assign sin_q  = 34'(i_cfg.sin_v);
    assign omc_q  = 34'(TRIG_ONE) - 34'(i_cfg.cos_v);

    always_comb begin
        en[6] = !r_v[6] || i_ready;
        for (int s = 5; s >= 1; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int s = 2; s <= 6; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_comb begin
        logic signed [RW-1:0] sum;
        for (int i = 0; i < 3; i++) begin
            sum = RW'(piv[i]) + RW'(r5_dc[i]) + RW'(r5_v[i]) + RW'(r5_u[i]);
            if (i_cfg.bad) begin
                n6_r[i] = r5_pt[i];
            end else if ((&sum[RW-1:CW-1]) || !(|sum[RW-1:CW-1])) begin
                n6_r[i] = CW'(sum);
            end else begin
                n6_r[i] = sum[RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r1_dd[i] <= DW'(pt[i]) - DW'(piv[i]);
                r1_pt[i] <= pt[i];
            end
            r1_last <= i_last;
        end
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_dt[i] <= PW'(f_mulq(RW'(r1_dd[i]), 34'(k[i])));
                r2_dc[i] <= PW'(f_mulq(RW'(r1_dd[i]), cos_q));
                r2_pt[i] <= r1_pt[i];
            end
            r2_ca[0] <= PW'(f_mulq(RW'(r1_dd[2]), 34'(k[1])));
            r2_cb[0] <= PW'(f_mulq(RW'(r1_dd[1]), 34'(k[2])));
            r2_ca[1] <= PW'(f_mulq(RW'(r1_dd[0]), 34'(k[2])));
            r2_cb[1] <= PW'(f_mulq(RW'(r1_dd[2]), 34'(k[0])));
            r2_ca[2] <= PW'(f_mulq(RW'(r1_dd[1]), 34'(k[0])));
            r2_cb[2] <= PW'(f_mulq(RW'(r1_dd[0]), 34'(k[1])));
            r2_last  <= r1_last;
        end
        if (en[3]) begin
            r3_dot <= SW'(r2_dt[0]) + SW'(r2_dt[1]) + SW'(r2_dt[2]);
            for (int i = 0; i < 3; i++) begin
                r3_cr[i] <= CRW'(r2_ca[i]) - CRW'(r2_cb[i]);
                r3_dc[i] <= r2_dc[i];
                r3_pt[i] <= r2_pt[i];
            end
            r3_last <= r2_last;
        end
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                r4_t[i]  <= TW'(f_mulq(RW'(r3_dot), 34'(k[i])));
                r4_u[i]  <= UW'(f_mulq(RW'(r3_cr[i]), sin_q));
                r4_dc[i] <= r3_dc[i];
                r4_pt[i] <= r3_pt[i];
            end
            r4_last <= r3_last;
        end
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                r5_v[i]  <= VW'(f_mulq(RW'(r4_t[i]), omc_q));
                r5_u[i]  <= r4_u[i];
                r5_dc[i] <= r4_dc[i];
                r5_pt[i] <= r4_pt[i];
            end
            r5_last <= r4_last;
        end
        if (en[6]) begin
            for (int i = 0; i < 3; i++) begin
                r6_r[i] <= n6_r[i];
            end
            r6_last <= r5_last;
        end
    end

    assign o_valid = r_v[6];
    assign o_rx    = r6_r[0];
    assign o_ry    = r6_r[1];
    assign o_rz    = r6_r[2];
    assign o_last  = r6_last;
    assign o_bad   = i_cfg.bad;

endmodule

// ===== rtl/rotate_point_about_axis.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata: point_x, point_y, point_z; tlast: last_point
// m_axis    out        tdata: rotated_x, rotated_y, rotated_z; tlast: end_of_set;
//                      tuser: axis_invalid
// cfg       in         wr_en, addr (register index), wdata
//
// One item per cycle while the derived values are ready and m_axis does not stall.
// After reset and after every register write a sequencer derives the unit axis,
// cosine and sine, mostly in the shared one-bit-per-cycle divider; s_axis is not ready meanwhile.
// A stall at m_axis holds each stage that has no free stage ahead of it.
module rotate_point_about_axis #(
    parameter int COORD_WIDTH = 32,
    localparam int TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // point_x, point_y, point_z, zero fill
    input  logic [TDATA_W-1:0] i_s_axis_tdata,
    input  logic               i_s_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // rotated_x, rotated_y, rotated_z, zero fill
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    output logic               o_m_axis_tlast,
    // axis_invalid
    output logic [0:0]         o_m_axis_tuser
);
    import rpa_pkg::*;

    localparam int CW = COORD_WIDTH;

    localparam logic [2:0] REG_PIVOT_X = 3'd0;
    localparam logic [2:0] REG_PIVOT_Y = 3'd1;
    localparam logic [2:0] REG_PIVOT_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X   = 3'd3;
    localparam logic [2:0] REG_DIR_Y   = 3'd4;
    localparam logic [2:0] REG_DIR_Z   = 3'd5;
    localparam logic [2:0] REG_ANGLE   = 3'd6;

    localparam logic signed [26:0] ANG_FULL    = 27'sd23592960;
    localparam logic [24:0]        ANG_QUARTER = 25'd5898240;
    localparam logic [24:0]        ANG_EIGHTH  = 25'd2949120;
    localparam logic [63:0]        PI_Q30      = 64'd3373259426;
    localparam logic [63:0]        DEG180_HALF = 64'd5898240;
    localparam logic [24:0]        RECIP45     = 25'd23860930;
    localparam logic signed [32:0] ONE33       = 33'sd1073741824;

    function automatic logic [31:0] f_mag(input logic signed [31:0] v);
        f_mag = v[31] ? 32'(-v) : 32'(v);
    endfunction

    logic signed [31:0] r_pivot [3];
    logic signed [31:0] r_dir   [3];
    logic signed [25:0] r_angle;
    logic               cfg_hit;

    t_dstate            r_dstate, n_dstate;
    t_dstate            r_ret, n_ret;
    logic [31:0]        r_sm [3], n_sm [3];
    logic [31:0]        r_mx, n_mx;
    logic [1:0]         r_idx, n_idx;
    logic [63:0]        r_sum, n_sum;
    logic [31:0]        r_root, n_root;
    logic [33:0]        r_srem, n_srem;
    logic [5:0]         r_cnt, n_cnt;
    logic [63:0]        r_num, n_num;
    logic [31:0]        r_den, n_den;
    logic [31:0]        r_drem, n_drem;
    logic signed [31:0] r_unit [3], n_unit [3];
    logic [24:0]        r_angw, n_angw;
    logic [1:0]         r_quad, n_quad;
    logic               r_flip, n_flip;
    logic [21:0]        r_remang, n_remang;
    logic [29:0]        r_rad, n_rad;
    logic [30:0]        r_term, n_term;
    logic [3:0]         r_tidx, n_tidx;
    logic signed [32:0] r_cs, n_cs;
    logic signed [32:0] r_sn, n_sn;
    logic signed [31:0] r_cos, n_cos;
    logic signed [31:0] r_sin, n_sin;

    t_axis_cfg          axis_cfg;
    logic               derived;
    logic               pipe_ready;
    logic signed [CW-1:0] rx, ry, rz;

    assign cfg_hit = i_cfg_wr_en && (i_cfg_addr <= REG_ANGLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot[0] <= '0;
            r_pivot[1] <= '0;
            r_pivot[2] <= '0;
            r_dir[0]   <= '0;
            r_dir[1]   <= '0;
            r_dir[2]   <= 32'sd65536;
            r_angle    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_PIVOT_X: r_pivot[0] <= i_cfg_wdata;
                REG_PIVOT_Y: r_pivot[1] <= i_cfg_wdata;
                REG_PIVOT_Z: r_pivot[2] <= i_cfg_wdata;
                REG_DIR_X:   r_dir[0]   <= i_cfg_wdata;
                REG_DIR_Y:   r_dir[1]   <= i_cfg_wdata;
                REG_DIR_Z:   r_dir[2]   <= i_cfg_wdata;
                REG_ANGLE:   r_angle    <= i_cfg_wdata[25:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstate <= DS_START;
        end else begin
            r_dstate <= n_dstate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_sm     <= n_sm;
        r_mx     <= n_mx;
        r_idx    <= n_idx;
        r_sum    <= n_sum;
        r_root   <= n_root;
        r_srem   <= n_srem;
        r_cnt    <= n_cnt;
        r_num    <= n_num;
        r_den    <= n_den;
        r_drem   <= n_drem;
        r_unit   <= n_unit;
        r_angw   <= n_angw;
        r_quad   <= n_quad;
        r_flip   <= n_flip;
        r_remang <= n_remang;
        r_rad    <= n_rad;
        r_term   <= n_term;
        r_tidx   <= n_tidx;
        r_cs     <= n_cs;
        r_sn     <= n_sn;
        r_cos    <= n_cos;
        r_sin    <= n_sin;
    end

    always_comb begin
        logic [31:0]        mx;
        logic [63:0]        sq;
        logic [35:0]        srem_sh;
        logic [35:0]        srem_test;
        logic [32:0]        drem_sh;
        logic signed [26:0] ang;
        logic [24:0]        rem_q;
        logic [63:0]        tp;
        logic signed [32:0] tq;
        logic signed [32:0] cs_c;
        logic signed [32:0] sn_c;
        logic signed [32:0] tmp;
        logic [31:0]        uq;
        logic [17:0]        mh;
        logic [17:0]        rh;
        logic [12:0]        qh;
        logic [42:0]        hprod;
        logic [23:0]        xl;
        logic [48:0]        lprod;

        mx        = '0;
        sq        = '0;
        srem_sh   = '0;
        srem_test = '0;
        drem_sh   = '0;
        ang       = '0;
        rem_q     = '0;
        tp        = '0;
        tq        = '0;
        cs_c      = '0;
        sn_c      = '0;
        tmp       = '0;
        uq        = '0;
        mh        = '0;
        rh        = '0;
        qh        = '0;
        hprod     = '0;
        xl        = '0;
        lprod     = '0;

        n_dstate = r_dstate;
        n_ret    = r_ret;
        n_sm     = r_sm;
        n_mx     = r_mx;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_root   = r_root;
        n_srem   = r_srem;
        n_cnt    = r_cnt;
        n_num    = r_num;
        n_den    = r_den;
        n_drem   = r_drem;
        n_unit   = r_unit;
        n_angw   = r_angw;
        n_quad   = r_quad;
        n_flip   = r_flip;
        n_remang = r_remang;
        n_rad    = r_rad;
        n_term   = r_term;
        n_tidx   = r_tidx;
        n_cs     = r_cs;
        n_sn     = r_sn;
        n_cos    = r_cos;
        n_sin    = r_sin;

        priority if (cfg_hit) begin
            n_dstate = DS_START;
        end else begin
            unique case (r_dstate)
                DS_START: begin
                    for (int i = 0; i < 3; i++) begin
                        n_sm[i] = f_mag(r_dir[i]);
                        if (n_sm[i] > mx) begin
                            mx = n_sm[i];
                        end
                    end
                    n_mx = mx;
                    if (mx == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            n_unit[i] = '0;
                        end
                        n_dstate = DS_ANGLE;
                    end else begin
                        n_dstate = DS_NORM;
                    end
                end
                DS_NORM: begin
                    if (r_mx[31:30] == 2'b00) begin
                        n_mx = r_mx << 1;
                        for (int i = 0; i < 3; i++) begin
                            n_sm[i] = r_sm[i] << 1;
                        end
                    end else begin
                        n_idx    = '0;
                        n_sum    = '0;
                        n_dstate = DS_SUMSQ;
                    end
                end
                DS_SUMSQ: begin
                    sq    = {32'd0, r_sm[r_idx]} * {32'd0, r_sm[r_idx]};
                    n_sum = r_sum + sq;
                    if (r_idx == 2'd2) begin
                        n_cnt    = 6'd31;
                        n_root   = '0;
                        n_srem   = '0;
                        n_dstate = DS_SQRT;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
                DS_SQRT: begin
                    srem_sh   = {r_srem, r_sum[63:62]};
                    srem_test = {2'b00, r_root, 2'b01};
                    if (srem_sh >= srem_test) begin
                        n_srem = 34'(srem_sh - srem_test);
                        n_root = {r_root[30:0], 1'b1};
                    end else begin
                        n_srem = srem_sh[33:0];
                        n_root = {r_root[30:0], 1'b0};
                    end
                    n_sum = r_sum << 2;
                    if (r_cnt == '0) begin
                        n_idx    = '0;
                        n_dstate = DS_UDIV;
                    end else begin
                        n_cnt = r_cnt - 6'd1;
                    end
                end
                DS_UDIV: begin
                    n_num    = ({32'd0, r_sm[r_idx]} << 30) + {33'd0, r_root[31:1]};
                    n_den    = r_root;
                    n_drem   = '0;
                    n_cnt    = 6'd63;
                    n_ret    = DS_UDONE;
                    n_dstate = DS_DIV;
                end
                DS_UDONE: begin
                    uq = r_num[31:0];
                    n_unit[r_idx] = r_dir[r_idx][31] ? -$signed(uq) : $signed(uq);
                    if (r_idx == 2'd2) begin
                        n_dstate = DS_ANGLE;
                    end else begin
                        n_idx    = r_idx + 2'd1;
                        n_dstate = DS_UDIV;
                    end
                end
                DS_ANGLE: begin
                    ang = 27'(r_angle);
                    if (ang < 0) begin
                        ang = ang + ANG_FULL;
                        if (ang < 0) begin
                            ang = ang + ANG_FULL;
                        end
                    end else if (ang >= ANG_FULL) begin
                        ang = ang - ANG_FULL;
                    end
                    n_angw   = ang[24:0];
                    n_dstate = DS_QUAD;
                end
                DS_QUAD: begin
                    if (r_angw >= 25'(3 * ANG_QUARTER)) begin
                        n_quad = 2'd3;
                        rem_q  = r_angw - 25'(3 * ANG_QUARTER);
                    end else if (r_angw >= 25'(2 * ANG_QUARTER)) begin
                        n_quad = 2'd2;
                        rem_q  = r_angw - 25'(2 * ANG_QUARTER);
                    end else if (r_angw >= ANG_QUARTER) begin
                        n_quad = 2'd1;
                        rem_q  = r_angw - ANG_QUARTER;
                    end else begin
                        n_quad = 2'd0;
                        rem_q  = r_angw;
                    end
                    n_flip   = rem_q > ANG_EIGHTH;
                    n_remang = n_flip ? 22'(ANG_QUARTER - rem_q) : rem_q[21:0];
                    n_dstate = DS_RMUL;
                end
                DS_RMUL: begin
                    n_num    = ({42'd0, r_remang} * PI_Q30) + DEG180_HALF;
                    n_dstate = DS_RHIGH;
                end
                DS_RHIGH: begin
                    // The divisor 180 * 2^16 is 2^18 times 45; the quotient by 45 is
                    // formed in two digits of 18 bits by reciprocal multiplication.
                    mh       = r_num[53:36];
                    hprod    = 43'(mh) * 43'(RECIP45);
                    qh       = hprod[42:30];
                    rh       = mh - 18'(qh) * 18'd45;
                    n_num    = {27'd0, qh, rh[5:0], r_num[35:18]};
                    n_dstate = DS_RDONE;
                end
                DS_RDONE: begin
                    xl       = r_num[23:0];
                    lprod    = 49'(xl) * 49'(RECIP45);
                    n_rad    = 30'({r_num[36:24], lprod[47:30]});
                    n_term   = 31'(TRIG_ONE);
                    n_cs     = ONE33;
                    n_sn     = '0;
                    n_tidx   = 4'd1;
                    n_dstate = DS_TMUL;
                end
                DS_TMUL: begin
                    tp       = {33'd0, r_term} * {34'd0, r_rad};
                    n_term   = 31'((tp + 64'd536870912) >> 30);
                    n_dstate = DS_TDIV;
                end
                DS_TDIV: begin
                    n_num    = {33'd0, r_term} + {61'd0, r_tidx[3:1]};
                    n_den    = {28'd0, r_tidx};
                    n_drem   = '0;
                    n_cnt    = 6'd63;
                    n_ret    = DS_TDONE;
                    n_dstate = DS_DIV;
                end
                DS_TDONE: begin
                    n_term = r_num[30:0];
                    tq     = $signed({2'b00, r_num[30:0]});
                    if (r_tidx[0]) begin
                        n_sn = r_tidx[1] ? r_sn - tq : r_sn + tq;
                    end else begin
                        n_cs = r_tidx[1] ? r_cs - tq : r_cs + tq;
                    end
                    if (r_tidx == 4'd14) begin
                        n_dstate = DS_FIN;
                    end else begin
                        n_tidx   = r_tidx + 4'd1;
                        n_dstate = DS_TMUL;
                    end
                end
                DS_FIN: begin
                    cs_c = (r_cs < 0) ? 33'sd0 : ((r_cs > ONE33) ? ONE33 : r_cs);
                    sn_c = (r_sn < 0) ? 33'sd0 : ((r_sn > ONE33) ? ONE33 : r_sn);
                    if (r_flip) begin
                        tmp  = cs_c;
                        cs_c = sn_c;
                        sn_c = tmp;
                    end
                    unique case (r_quad)
                        2'd0: begin
                            n_cos = 32'(cs_c);
                            n_sin = 32'(sn_c);
                        end
                        2'd1: begin
                            n_cos = 32'(-sn_c);
                            n_sin = 32'(cs_c);
                        end
                        2'd2: begin
                            n_cos = 32'(-cs_c);
                            n_sin = 32'(-sn_c);
                        end
                        default: begin
                            n_cos = 32'(sn_c);
                            n_sin = 32'(-cs_c);
                        end
                    endcase
                    n_dstate = DS_READY;
                end
                DS_DIV: begin
                    drem_sh = {r_drem, r_num[63]};
                    if (drem_sh >= {1'b0, r_den}) begin
                        n_drem = 32'(drem_sh - {1'b0, r_den});
                        n_num  = {r_num[62:0], 1'b1};
                    end else begin
                        n_drem = drem_sh[31:0];
                        n_num  = {r_num[62:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        n_dstate = r_ret;
                    end else begin
                        n_cnt = r_cnt - 6'd1;
                    end
                end
                DS_READY: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign derived = (r_dstate == DS_READY);

    assign axis_cfg.pivot_x = r_pivot[0];
    assign axis_cfg.pivot_y = r_pivot[1];
    assign axis_cfg.pivot_z = r_pivot[2];
    assign axis_cfg.unit_u  = r_unit[0];
    assign axis_cfg.unit_v  = r_unit[1];
    assign axis_cfg.unit_w  = r_unit[2];
    assign axis_cfg.cos_v   = r_cos;
    assign axis_cfg.sin_v   = r_sin;
    assign axis_cfg.bad     = (r_unit[0] == '0) && (r_unit[1] == '0) && (r_unit[2] == '0);

    rpa_pipe #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (axis_cfg),
        .i_valid (i_s_axis_tvalid && derived),
        .o_ready (pipe_ready),
        .i_px    (i_s_axis_tdata[CW-1:0]),
        .i_py    (i_s_axis_tdata[2*CW-1:CW]),
        .i_pz    (i_s_axis_tdata[3*CW-1:2*CW]),
        .i_last  (i_s_axis_tlast),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_rx    (rx),
        .o_ry    (ry),
        .o_rz    (rz),
        .o_last  (o_m_axis_tlast),
        .o_bad   (o_m_axis_tuser[0])
    );

    assign o_s_axis_tready = pipe_ready && derived;
    assign o_m_axis_tdata  = TDATA_W'({rz, ry, rx});

`ifndef SYNTHESIS
    ap_ready_needs_derived: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (r_dstate == DS_READY))
        else $error("input ready while derived values are not valid");

    ap_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_dstate == DS_START))
        else $error("register write did not restart derivation");

    ap_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dstate == DS_READY) |->
            (r_cos <= TRIG_ONE && r_cos >= -TRIG_ONE &&
             r_sin <= TRIG_ONE && r_sin >= -TRIG_ONE))
        else $error("cosine or sine outside unit range");
`endif

endmodule

// ===== tb/tb_rotate_point_about_axis.sv =====
`timescale 1ns / 1ps

class rotated_point_tracker;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
        logic        invalid;
    } t_rotated;

    logic [31:0] regs[7];
    longint      unit_k[3];
    longint      cos_q30;
    longint      sin_q30;
    t_rotated    expected_points[$];
    int          mismatches;

    function new();
        foreach (regs[i]) regs[i] = '0;
        regs[5] = 32'd65536;
        mismatches = 0;
        derive_axis();
    endfunction

    function longint mulq(longint p, longint q);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] r;
        ma = (p < 0) ? 64'd0 - p : p;
        mb = (q < 0) ? 64'd0 - q : q;
        r = ({64'd0, ma} * {64'd0, mb} + (128'd1 << 29)) >> 30;
        if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
        return ((p < 0) != (q < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function void derive_axis();
        longint      dir[3];
        logic [63:0] sm[3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] q;
        longint      full;
        longint      quarter;
        longint      ang;
        longint      rem;
        longint      rad;
        longint      term;
        longint      cs;
        longint      sn;
        longint      tmp;
        int          quad;
        bit          flip;
        full = longint'(360) <<< 16;
        quarter = longint'(90) <<< 16;
        mx = 0;
        sum = 0;
        root = 0;
        for (int i = 0; i < 3; i++) begin
            dir[i] = $signed(regs[3 + i]);
            sm[i] = (dir[i] < 0) ? 64'd0 - dir[i] : dir[i];
            if (sm[i] > mx) mx = sm[i];
            unit_k[i] = 0;
        end
        if (mx != 0) begin
            while (mx < (64'd1 << 30)) begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) sm[i] = sm[i] << 1;
            end
            for (int i = 0; i < 3; i++) sum += sm[i] * sm[i];
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= sum) root = trial;
            end
            for (int i = 0; i < 3; i++) begin
                q = ((sm[i] << 30) + root / 2) / root;
                unit_k[i] = (dir[i] < 0) ? -longint'(q) : longint'(q);
            end
        end
        ang = $signed(regs[6][25:0]);
        ang = ang % full;
        if (ang < 0) ang += full;
        quad = int'(ang / quarter);
        rem = ang - longint'(quad) * quarter;
        flip = rem > (longint'(45) <<< 16);
        if (flip) rem = quarter - rem;
        rad = (rem * 64'sd3373259426 + (longint'(90) <<< 16)) / (longint'(180) <<< 16);
        term = 64'sd1 <<< 30;
        cs = term;
        sn = 0;
        for (int i = 1; i <= 14; i++) begin
            term = (term * rad + (64'sd1 <<< 29)) >>> 30;
            term = (term + i / 2) / i;
            if (i & 1) sn += (i & 2) ? -term : term;
            else cs += (i & 2) ? -term : term;
        end
        if (cs < 0) cs = 0;
        if (cs > (64'sd1 <<< 30)) cs = 64'sd1 <<< 30;
        if (sn < 0) sn = 0;
        if (sn > (64'sd1 <<< 30)) sn = 64'sd1 <<< 30;
        if (flip) begin
            tmp = cs;
            cs = sn;
            sn = tmp;
        end
        case (quad & 3)
            0: begin cos_q30 = cs; sin_q30 = sn; end
            1: begin cos_q30 = -sn; sin_q30 = cs; end
            2: begin cos_q30 = -cs; sin_q30 = -sn; end
            default: begin cos_q30 = sn; sin_q30 = -cs; end
        endcase
    endfunction

    function void write_reg(int index, logic [31:0] value);
        if (index >= 7) return;
        regs[index] = (index == 6) ? {6'd0, value[25:0]} : value;
        derive_axis();
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        longint   pt[3];
        longint   piv[3];
        longint   dd[3];
        longint   cr[3];
        longint   res[3];
        longint   dot;
        longint   omc;
        t_rotated e;
        pt[0] = $signed(x);
        pt[1] = $signed(y);
        pt[2] = $signed(z);
        for (int i = 0; i < 3; i++) begin
            piv[i] = $signed(regs[i]);
            dd[i] = pt[i] - piv[i];
        end
        e.invalid = unit_k[0] == 0 && unit_k[1] == 0 && unit_k[2] == 0;
        dot = mulq(unit_k[0], dd[0]) + mulq(unit_k[1], dd[1]) + mulq(unit_k[2], dd[2]);
        cr[0] = mulq(unit_k[1], dd[2]) - mulq(unit_k[2], dd[1]);
        cr[1] = mulq(unit_k[2], dd[0]) - mulq(unit_k[0], dd[2]);
        cr[2] = mulq(unit_k[0], dd[1]) - mulq(unit_k[1], dd[0]);
        omc = (64'sd1 <<< 30) - cos_q30;
        for (int i = 0; i < 3; i++) begin
            if (e.invalid) res[i] = pt[i];
            else res[i] = piv[i] + mulq(dd[i], cos_q30) + mulq(mulq(unit_k[i], dot), omc)
                          + mulq(cr[i], sin_q30);
        end
        e.x = sat32(res[0]);
        e.y = sat32(res[1]);
        e.z = sat32(res[2]);
        e.last = last;
        expected_points.push_back(e);
    endfunction

    function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last,
                               logic invalid);
        t_rotated e;
        if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected item x=%h y=%h z=%h", x, y, z);
            return;
        end
        e = expected_points.pop_front();
        if (x !== e.x || y !== e.y || z !== e.z || last !== e.last || invalid !== e.invalid)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch: expected %h %h %h last %b inv %b, got %h %h %h last %b inv %b",
                         e.x, e.y, e.z, e.last, e.invalid, x, y, z, last, invalid);
        end
    endfunction

endclass

module tb_rotate_point_about_axis;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [95:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [0:0]  o_m_axis_tuser;

    int send_idle_pct;
    int recv_idle_pct;
    rotated_point_tracker tracker = new();

    rotate_point_about_axis i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_s_axis_tlast(i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tlast(o_m_axis_tlast),
        .o_m_axis_tuser(o_m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_result(o_m_axis_tdata[31:0], o_m_axis_tdata[63:32],
                                 o_m_axis_tdata[95:64], o_m_axis_tlast, o_m_axis_tuser[0]);
        i_m_axis_tready <= ($urandom % 100) >= recv_idle_pct;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom % 6)
            0: return $urandom;
            1: return ($urandom % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(2000 * 65536) - 1000 * 65536;
        endcase
    endfunction

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        while (($urandom % 100) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {z, y, x};
        i_s_axis_tlast <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_point(x, y, z, last);
    endtask

    task automatic write_reg(int index, logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= index[2:0];
        i_cfg_wdata <= value;
        @(posedge i_clk);
        tracker.write_reg(index, value);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_points.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_axis(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                            logic [25:0] ang);
        drain();
        write_reg(0, px);
        write_reg(1, py);
        write_reg(2, pz);
        write_reg(3, dx);
        write_reg(4, dy);
        write_reg(5, dz);
        write_reg(6, {6'($urandom), ang});
        if ($urandom % 2) write_reg(7, $urandom);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
            send_point(rand_coord(), rand_coord(), rand_coord(), ($urandom % 8) == 0);
    endtask

    initial begin
        logic [31:0] d[3];
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_wdata <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tlast <= 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 54;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);

        set_axis(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 26'd0);
        send_point(32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000, 1'b1);
        send_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 1'b0);

        set_axis(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 26'(360 * 65536));
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        set_axis(32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
                 32'h7FFF_FFFF, 32'h0000_0001, 32'd0, -26'(360 * 65536));
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h0010_0000, 32'hFFF0_0000, 32'h0001_0000, 1'b1);
        for (int a = 0; a < 8; a++) begin
            set_axis(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                     32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 26'(a * 45 * 65536 + 3));
            send_point(32'h0005_0000, 32'hFFFB_8000, 32'h0003_4000, a[0]);
        end

        for (int phase = 0; phase < 14; phase++) begin
            if (phase == 5) begin
                send_idle_pct = 54;
                recv_idle_pct = 7;
            end else if (phase == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 3; i++) begin
                case ($urandom % 4)
                    0: d[i] = $urandom;
                    1: d[i] = 32'd0;
                    default: d[i] = $urandom_range(20 * 65536) - 10 * 65536;
                endcase
            end
            if (d[0] == 0 && d[1] == 0 && d[2] == 0 && ($urandom % 2)) d[2] = 32'h0001_0000;
            set_axis(rand_coord(), rand_coord(), rand_coord(), d[0], d[1], d[2],
                     26'($urandom_range(47185920) - 23592960));
            send_random(75);
        end

        drain();
        if (tracker.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
